[design/lcdseq_pkg.sv]
// Package for the character LCD command sequencer.
// Holds widths, action codes, shared types and the expander byte tables.
// No dependencies.
package lcdseq_pkg;

    localparam int ADDR_W = 7;
    localparam int BYTE_W = 8;
    localparam int WAIT_W = 10;
    localparam int ACT_W  = 4;
    localparam int IDX_W  = 5;

    // Index of the final write of each kind of operation
    localparam logic [IDX_W-1:0] INIT_LAST_IDX = 5'd28;
    localparam logic [IDX_W-1:0] BYTE_LAST_IDX = 5'd3;
    localparam logic [IDX_W-1:0] BL_LAST_IDX   = 5'd0;

    // LCD operation codes
    localparam logic [ACT_W-1:0] ACT_INIT      = 4'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR     = 4'd1;
    localparam logic [ACT_W-1:0] ACT_HOME      = 4'd2;
    localparam logic [ACT_W-1:0] ACT_ENTRY     = 4'd3;
    localparam logic [ACT_W-1:0] ACT_DISPLAY   = 4'd4;
    localparam logic [ACT_W-1:0] ACT_SHIFT     = 4'd5;
    localparam logic [ACT_W-1:0] ACT_FUNCTION  = 4'd6;
    localparam logic [ACT_W-1:0] ACT_CGRAM     = 4'd7;
    localparam logic [ACT_W-1:0] ACT_DDRAM     = 4'd8;
    localparam logic [ACT_W-1:0] ACT_DATA      = 4'd9;
    localparam logic [ACT_W-1:0] ACT_BACKLIGHT = 4'd10;

    // Expander bit positions
    localparam logic [BYTE_W-1:0] EN_MASK = 8'h04;
    localparam int                BL_POS  = 3;

    localparam logic [WAIT_W-1:0] WAIT_SHORT = 10'd1;
    localparam logic [WAIT_W-1:0] WAIT_LONG  = 10'd3;

    // Kind of write sequence an operation produces
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_INIT = 2'd1,
        KIND_BYTE = 2'd2,
        KIND_BL   = 2'd3
    } kind_t;

    // Controller to datapath
    typedef struct packed {
        logic             capture;
        logic             emit;
        logic             last;
        kind_t            kind;
        logic [IDX_W-1:0] idx;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  out_free;
    } dp_stat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] bus_byte;
        logic [WAIT_W-1:0] wait_ms;
    } bus_write_t;

    // Operation decode
    function automatic kind_t decode_kind(input logic [ACT_W-1:0] action);
        kind_t k;
        case (action)
            ACT_INIT:      k = KIND_INIT;
            ACT_CLEAR,
            ACT_HOME,
            ACT_ENTRY,
            ACT_DISPLAY,
            ACT_SHIFT,
            ACT_FUNCTION,
            ACT_CGRAM,
            ACT_DDRAM,
            ACT_DATA:      k = KIND_BYTE;
            ACT_BACKLIGHT: k = KIND_BL;
            default:       k = KIND_NONE;
        endcase
        return k;
    endfunction

    // LCD command or data byte for a single-byte operation
    function automatic logic [BYTE_W-1:0] build_cmd(
        input logic [ACT_W-1:0]  action,
        input logic              a,
        input logic              b,
        input logic              c,
        input logic [BYTE_W-1:0] v
    );
        logic [BYTE_W-1:0] r;
        case (action)
            ACT_CLEAR:    r = 8'h01;
            ACT_HOME:     r = 8'h02;
            ACT_ENTRY:    r = {6'b000001, a, b};
            ACT_DISPLAY:  r = {5'b00001, a, b, c};
            ACT_SHIFT:    r = {4'b0001, a, b, 2'b00};
            ACT_FUNCTION: r = {3'b001, a, b, c, 2'b00};
            ACT_CGRAM:    r = {2'b01, v[5:0]};
            ACT_DDRAM:    r = {1'b1, v[6:0]};
            ACT_DATA:     r = v;
            default:      r = '0;
        endcase
        return r;
    endfunction

    // One of the four writes of a byte: high nibble first, enable set then cleared
    function automatic bus_write_t byte_write(
        input logic [BYTE_W-1:0] cmd,
        input logic              rs,
        input logic              bl,
        input logic              long_wait,
        input logic [1:0]        step
    );
        bus_write_t w;
        logic [3:0] nib;
        nib        = step[1] ? cmd[3:0] : cmd[7:4];
        w.bus_byte = {nib, bl, ~step[0], 1'b0, rs};
        if (step == 2'd3) begin
            w.wait_ms = long_wait ? WAIT_LONG : WAIT_SHORT;
        end else begin
            w.wait_ms = '0;
        end
        return w;
    endfunction

    // Fixed power-up sequence, 29 writes
    function automatic bus_write_t init_write(input logic [IDX_W-1:0] idx);
        bus_write_t w;
        case (idx)
            5'd0:    w = '{8'h00, 10'd1000};
            5'd1:    w = '{8'h34, 10'd0};
            5'd2:    w = '{8'h30, 10'd5};
            5'd3:    w = '{8'h34, 10'd0};
            5'd4:    w = '{8'h30, 10'd1};
            5'd5:    w = '{8'h34, 10'd0};
            5'd6:    w = '{8'h30, 10'd1};
            5'd7:    w = '{8'h24, 10'd0};
            5'd8:    w = '{8'h20, 10'd1};
            5'd9:    w = '{8'h24, 10'd0};
            5'd10:   w = '{8'h20, 10'd0};
            5'd11:   w = '{8'h84, 10'd0};
            5'd12:   w = '{8'h80, 10'd1};
            5'd13:   w = '{8'h04, 10'd0};
            5'd14:   w = '{8'h00, 10'd0};
            5'd15:   w = '{8'h84, 10'd0};
            5'd16:   w = '{8'h80, 10'd1};
            5'd17:   w = '{8'h04, 10'd0};
            5'd18:   w = '{8'h00, 10'd0};
            5'd19:   w = '{8'h14, 10'd0};
            5'd20:   w = '{8'h10, 10'd3};
            5'd21:   w = '{8'h04, 10'd0};
            5'd22:   w = '{8'h00, 10'd0};
            5'd23:   w = '{8'h64, 10'd0};
            5'd24:   w = '{8'h60, 10'd1};
            5'd25:   w = '{8'h0C, 10'd0};
            5'd26:   w = '{8'h08, 10'd0};
            5'd27:   w = '{8'hFC, 10'd0};
            5'd28:   w = '{8'hF8, 10'd1};
            default: w = '{8'h00, 10'd0};
        endcase
        return w;
    endfunction

endpackage

[design/lcdseq_ctrl.sv]
// Controller of the LCD command sequencer: steps through the writes of one operation.
// Depends on lcdseq_pkg.
module lcdseq_ctrl
    import lcdseq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    kind_t            kind_reg, kind_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] last_idx;
    logic             is_last;

    // Final write index for the running operation
    always_comb begin
        case (kind_reg)
            KIND_INIT: last_idx = INIT_LAST_IDX;
            KIND_BYTE: last_idx = BYTE_LAST_IDX;
            default:   last_idx = BL_LAST_IDX;
        endcase
    end

    assign is_last = (idx_reg == last_idx);
    assign s_ready = (state_reg == ST_IDLE);

    // Sequencing
    always_comb begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        idx_next    = idx_reg;
        cmd.capture = 1'b0;
        cmd.emit    = 1'b0;
        cmd.last    = is_last;
        cmd.kind    = kind_reg;
        cmd.idx     = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    // unknown operations are taken and dropped
                    if (stat.kind != KIND_NONE) begin
                        state_next = ST_RUN;
                        kind_next  = stat.kind;
                        idx_next   = '0;
                    end
                end
            end
            ST_RUN: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= KIND_NONE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

[design/lcdseq_dp.sv]
// Datapath of the LCD command sequencer: operation registers, byte build, output register.
// Depends on lcdseq_pkg.
module lcdseq_dp
    import lcdseq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [ADDR_W-1:0] cfg_data,
    input  logic [ACT_W-1:0]  s_action,
    input  logic              s_bit_a,
    input  logic              s_bit_b,
    input  logic              s_bit_c,
    input  logic [BYTE_W-1:0] s_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ADDR_W-1:0] m_device_address,
    output logic [BYTE_W-1:0] m_bus_byte,
    output logic [WAIT_W-1:0] m_wait_ms,
    output logic              m_last,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat
);

    logic [ADDR_W-1:0] addr_reg;
    logic              bl_reg;
    logic [BYTE_W-1:0] cmd_byte_reg;
    logic              rs_reg;
    logic              long_wait_reg;
    logic              valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    bus_write_t        out_write_reg;
    logic              out_last_reg;
    bus_write_t        write_next;

    assign stat.kind     = decode_kind(s_action);
    assign stat.out_free = !valid_reg || m_ready;

    // Configuration and backlight state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= '0;
            bl_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                addr_reg <= cfg_data;
            end
            if (cmd.capture) begin
                if (s_action == ACT_INIT) begin
                    bl_reg <= 1'b1;
                end else if (s_action == ACT_BACKLIGHT) begin
                    bl_reg <= s_bit_a;
                end
            end
        end
    end

    // Operation capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_byte_reg  <= build_cmd(s_action, s_bit_a, s_bit_b, s_bit_c, s_value);
            rs_reg        <= (s_action == ACT_DATA);
            long_wait_reg <= (s_action == ACT_CLEAR) || (s_action == ACT_HOME);
        end
    end

    // Next expander write
    always_comb begin
        case (cmd.kind)
            KIND_INIT: write_next = init_write(cmd.idx);
            KIND_BYTE: write_next = byte_write(cmd_byte_reg, rs_reg, bl_reg,
                                               long_wait_reg, cmd.idx[1:0]);
            KIND_BL: begin
                write_next.bus_byte         = '0;
                write_next.bus_byte[BL_POS] = bl_reg;
                write_next.wait_ms          = '0;
            end
            default:   write_next = '0;
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_addr_reg  <= addr_reg;
            out_write_reg <= write_next;
            out_last_reg  <= cmd.last;
        end
    end

    assign m_valid          = valid_reg;
    assign m_device_address = out_addr_reg;
    assign m_bus_byte       = out_write_reg.bus_byte;
    assign m_wait_ms        = out_write_reg.wait_ms;
    assign m_last           = out_last_reg;

endmodule

[design/char_lcd_i2c_command_sequencer.sv]
// Character LCD command sequencer for an I2C port expander, 4-bit mode.
// First expander write: registered from the run state once the output register is free.
// Throughput: one write per cycle while m_ready holds; a byte operation makes 4 writes,
// init 29, backlight 1, paced by the write step counter; a new operation waits for idle.
// Reset (aresetn low, synchronous): address 0, backlight off, no write pending.
// Depends on lcdseq_pkg, lcdseq_ctrl, lcdseq_dp.
module char_lcd_i2c_command_sequencer
    import lcdseq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ADDR_W-1:0] cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [ACT_W-1:0]  s_action,
    input  logic              s_bit_a,
    input  logic              s_bit_b,
    input  logic              s_bit_c,
    input  logic [BYTE_W-1:0] s_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ADDR_W-1:0] m_device_address,
    output logic [BYTE_W-1:0] m_bus_byte,
    output logic [WAIT_W-1:0] m_wait_ms,
    output logic              m_last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    lcdseq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lcdseq_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_data         (cfg_data),
        .s_action         (s_action),
        .s_bit_a          (s_bit_a),
        .s_bit_b          (s_bit_b),
        .s_bit_c          (s_bit_c),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_device_address (m_device_address),
        .m_bus_byte       (m_bus_byte),
        .m_wait_ms        (m_wait_ms),
        .m_last           (m_last),
        .cmd              (cmd),
        .stat             (stat)
    );

    // Reset leaves no write pending
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("write pending after reset");

    // Unknown operations are dropped without leaving idle
    a_drop_unknown: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_action > ACT_BACKLIGHT) |=> s_ready)
        else $error("unknown operation started a sequence");

    // A known operation occupies the sequencer
    a_known_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_action <= ACT_BACKLIGHT) |=> !s_ready)
        else $error("known operation did not start a sequence");

    // While a non-final write is shown, the sequence is still running
    a_mid_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("new operation taken before sequence finished");

endmodule

[test/char_lcd_i2c_command_sequencer_test.sv]
// Testbench for char_lcd_i2c_command_sequencer: LCD operations in, expander writes out.
// Predicts every expander write in 4-bit mode and checks each transfer field by field.
// Depends on lcdseq_pkg and the sequencer RTL.
`timescale 1ns / 100ps

module char_lcd_i2c_command_sequencer_test
    import lcdseq_pkg::*;
();

    localparam int                HALF_PERIOD = 10;
    localparam int                STALL_LIMIT = 4000;
    localparam int                SETTLE_CYCLES = 10;
    localparam int                MAX_REPORTS = 10;
    localparam int                RANDOM_PHASES = 8;
    localparam int                OPS_PER_PHASE = 55;
    localparam logic [ACT_W-1:0]  ACT_MAX = {ACT_W{1'b1}};

    // One LCD operation as presented on the input channel
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic              bit_a;
        logic              bit_b;
        logic              bit_c;
        logic [BYTE_W-1:0] value;
    } lcd_op_t;

    // One expander write as seen on the result channel
    typedef struct packed {
        logic [ADDR_W-1:0] dev_addr;
        logic [BYTE_W-1:0] bus_byte;
        logic [WAIT_W-1:0] pause_ms;
        logic              is_last;
    } expander_write_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [ADDR_W-1:0] cfg_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [ACT_W-1:0]  s_action = '0;
    logic              s_bit_a = 1'b0;
    logic              s_bit_b = 1'b0;
    logic              s_bit_c = 1'b0;
    logic [BYTE_W-1:0] s_value = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [ADDR_W-1:0] m_device_address;
    logic [BYTE_W-1:0] m_bus_byte;
    logic [WAIT_W-1:0] m_wait_ms;
    logic              m_last;

    // Shadow of the block's configuration and state
    logic [ADDR_W-1:0] addr_model = '0;
    logic              backlight_model = 1'b0;

    expander_write_t   pending_writes[$];
    int                error_count = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                quiet_cycles = 0;

    char_lcd_i2c_command_sequencer u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_bit_a          (s_bit_a),
        .s_bit_b          (s_bit_b),
        .s_bit_c          (s_bit_c),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_device_address (m_device_address),
        .m_bus_byte       (m_bus_byte),
        .m_wait_ms        (m_wait_ms),
        .m_last           (m_last)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Expected expander writes
    // ------------------------------------------------------------------
    function automatic void queue_write(input logic [BYTE_W-1:0] bus,
                                        input logic [WAIT_W-1:0] delay);
        expander_write_t w;
        w.dev_addr = addr_model;
        w.bus_byte = bus;
        w.pause_ms = delay;
        w.is_last  = 1'b0;
        pending_writes.push_back(w);
    endfunction

    // Enable-set write, then enable-cleared write carrying the wait
    function automatic void queue_nibble(input logic [3:0] nib, input logic rs,
                                         input logic bl, input logic [WAIT_W-1:0] delay);
        logic [BYTE_W-1:0] msg;
        msg         = {nib, 4'b0000};
        msg[BL_POS] = bl;
        msg[0]      = rs;
        queue_write(msg | EN_MASK, '0);
        queue_write(msg, delay);
    endfunction

    function automatic void queue_lcd_byte(input logic [BYTE_W-1:0] lcd_byte, input logic rs,
                                           input logic bl, input logic [WAIT_W-1:0] delay);
        queue_nibble(lcd_byte[7:4], rs, bl, '0);
        queue_nibble(lcd_byte[3:0], rs, bl, delay);
    endfunction

    // Works out the writes for one accepted operation and updates the shadow state
    function automatic void predict_writes(input lcd_op_t op);
        int              depth;
        logic            bl;
        logic [BYTE_W-1:0] bl_only;
        expander_write_t tail;
        depth = pending_writes.size();
        bl    = backlight_model;
        case (op.action)
            ACT_INIT: begin
                queue_write(8'h00, 10'd1000);
                queue_nibble(4'h3, 1'b0, 1'b0, 10'd5);
                queue_nibble(4'h3, 1'b0, 1'b0, 10'd1);
                queue_nibble(4'h3, 1'b0, 1'b0, 10'd1);
                queue_nibble(4'h2, 1'b0, 1'b0, 10'd1);
                queue_lcd_byte(8'h28, 1'b0, 1'b0, 10'd1);
                queue_lcd_byte(8'h08, 1'b0, 1'b0, 10'd1);
                queue_lcd_byte(8'h01, 1'b0, 1'b0, 10'd3);
                queue_lcd_byte(8'h06, 1'b0, 1'b0, 10'd1);
                backlight_model = 1'b1;
                queue_lcd_byte(8'h0F, 1'b0, 1'b1, 10'd1);
            end
            ACT_CLEAR:    queue_lcd_byte(8'h01, 1'b0, bl, 10'd3);
            ACT_HOME:     queue_lcd_byte(8'h02, 1'b0, bl, 10'd3);
            ACT_ENTRY:    queue_lcd_byte({6'b000001, op.bit_a, op.bit_b}, 1'b0, bl, 10'd1);
            ACT_DISPLAY:  queue_lcd_byte({5'b00001, op.bit_a, op.bit_b, op.bit_c},
                                         1'b0, bl, 10'd1);
            ACT_SHIFT:    queue_lcd_byte({4'b0001, op.bit_a, op.bit_b, 2'b00},
                                         1'b0, bl, 10'd1);
            ACT_FUNCTION: queue_lcd_byte({3'b001, op.bit_a, op.bit_b, op.bit_c, 2'b00},
                                         1'b0, bl, 10'd1);
            ACT_CGRAM:    queue_lcd_byte({2'b01, op.value[5:0]}, 1'b0, bl, 10'd1);
            ACT_DDRAM:    queue_lcd_byte({1'b1, op.value[6:0]}, 1'b0, bl, 10'd1);
            ACT_DATA:     queue_lcd_byte(op.value, 1'b1, bl, 10'd1);
            ACT_BACKLIGHT: begin
                backlight_model = op.bit_a;
                bl_only         = '0;
                bl_only[BL_POS] = op.bit_a;
                queue_write(bl_only, '0);
            end
            default: ; // unknown operations are dropped
        endcase
        // Flag the final write of this operation
        if (pending_writes.size() > depth) begin
            tail         = pending_writes.pop_back();
            tail.is_last = 1'b1;
            pending_writes.push_back(tail);
        end
    endfunction

    function automatic void check_write(input expander_write_t got);
        expander_write_t want;
        if (pending_writes.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("unexpected write: addr %h byte %h wait %0d last %b",
                         got.dev_addr, got.bus_byte, got.pause_ms, got.is_last);
            return;
        end
        want = pending_writes.pop_front();
        if (got.dev_addr !== want.dev_addr || got.bus_byte !== want.bus_byte ||
            got.pause_ms !== want.pause_ms || got.is_last !== want.is_last) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("mismatch: expected %h %h %0d %b, got %h %h %0d %b",
                         want.dev_addr, want.bus_byte, want.pause_ms, want.is_last,
                         got.dev_addr, got.bus_byte, got.pause_ms, got.is_last);
        end
    endfunction

    // Monitor: samples pre-edge values of every channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                addr_model = cfg_data;
            if (s_valid && s_ready)
                predict_writes(lcd_op_t'{s_action, s_bit_a, s_bit_b, s_bit_c, s_value});
            if (m_valid && m_ready)
                check_write(expander_write_t'{m_device_address, m_bus_byte, m_wait_ms,
                                              m_last});
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic lcd_op_t make_op(input logic [ACT_W-1:0] action, input logic a,
                                        input logic b, input logic c,
                                        input logic [BYTE_W-1:0] v);
        return lcd_op_t'{action, a, b, c, v};
    endfunction

    function automatic lcd_op_t random_op();
        lcd_op_t op;
        int      pick;
        op.bit_a = 1'($urandom_range(0, 1));
        op.bit_b = 1'($urandom_range(0, 1));
        op.bit_c = 1'($urandom_range(0, 1));
        op.value = 8'($urandom_range(0, 255));
        pick     = $urandom_range(0, 99);
        if (pick < 4)
            op.action = ACT_INIT;
        else if (pick < 9)
            op.action = ACT_W'($urandom_range(ACT_BACKLIGHT + 1, ACT_MAX));
        else if (pick < 19)
            op.action = ACT_BACKLIGHT;
        else
            op.action = ACT_W'($urandom_range(ACT_CLEAR, ACT_DATA));
        return op;
    endfunction

    // 0: no idling, 1: sender idle, 2: receiver stalls, 3: light idling on both
    function automatic void set_idling(input int mode);
        case (mode)
            1:       begin send_idle_pct = 60; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 60; end
            3:       begin send_idle_pct = 6;  recv_stall_pct = 6;  end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endfunction

    // Called at a rising edge; returns at the edge of the transfer with valid still high
    task automatic send_op(input lcd_op_t op);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= op.action;
        s_bit_a  <= op.bit_a;
        s_bit_b  <= op.bit_b;
        s_bit_c  <= op.bit_c;
        s_value  <= op.value;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid, wait for every expected write, then let the block settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_writes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_addr(input logic [ADDR_W-1:0] addr);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= addr;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset address and backlight off before any init
    task automatic test_after_reset();
        send_op(make_op(ACT_CLEAR, 1'b1, 1'b1, 1'b1, 8'hFF));
        send_op(make_op(ACT_DATA, 1'b0, 1'b0, 1'b0, 8'hFF));
    endtask

    // Power-up sequence, leaves the backlight on
    task automatic test_init();
        write_addr(7'h7F);
        send_op(make_op(ACT_INIT, 1'b0, 1'b1, 1'b0, 8'h5A));
    endtask

    // Single-byte commands other than clear with field extremes; unused bits set to be ignored
    task automatic test_commands();
        send_op(make_op(ACT_HOME,     1'b1, 1'b0, 1'b1, 8'hFF));
        send_op(make_op(ACT_ENTRY,    1'b1, 1'b0, 1'b1, 8'hFF));
        send_op(make_op(ACT_ENTRY,    1'b0, 1'b1, 1'b0, 8'h00));
        send_op(make_op(ACT_DISPLAY,  1'b1, 1'b1, 1'b1, 8'h00));
        send_op(make_op(ACT_DISPLAY,  1'b0, 1'b0, 1'b0, 8'hFF));
        send_op(make_op(ACT_SHIFT,    1'b1, 1'b1, 1'b1, 8'hFF));
        send_op(make_op(ACT_FUNCTION, 1'b1, 1'b1, 1'b1, 8'h00));
        send_op(make_op(ACT_FUNCTION, 1'b0, 1'b0, 1'b0, 8'hFF));
        send_op(make_op(ACT_CGRAM,    1'b1, 1'b1, 1'b1, 8'hFF));
        send_op(make_op(ACT_CGRAM,    1'b0, 1'b0, 1'b0, 8'h00));
        send_op(make_op(ACT_DDRAM,    1'b1, 1'b1, 1'b1, 8'hFF));
        send_op(make_op(ACT_DDRAM,    1'b0, 1'b0, 1'b0, 8'h00));
        send_op(make_op(ACT_DATA,     1'b1, 1'b1, 1'b1, 8'h00));
        send_op(make_op(ACT_DATA,     1'b0, 1'b0, 1'b0, 8'hA5));
    endtask

    // Backlight switching and operations that must be dropped
    task automatic test_backlight_and_unknown();
        write_addr(7'h00);
        send_op(make_op(ACT_BACKLIGHT, 1'b0, 1'b1, 1'b1, 8'hFF));
        send_op(make_op(ACT_CLEAR, 1'b0, 1'b0, 1'b0, 8'h00));
        send_op(make_op(ACT_W'(ACT_BACKLIGHT + 1), 1'b1, 1'b1, 1'b1, 8'hFF));
        send_op(make_op(ACT_MAX, 1'b1, 1'b0, 1'b1, 8'h81));
        send_op(make_op(ACT_BACKLIGHT, 1'b1, 1'b0, 1'b0, 8'h00));
        send_op(make_op(ACT_DATA, 1'b1, 1'b0, 1'b1, 8'h3C));
    endtask

    // Random operations across idling patterns and device addresses
    task automatic test_random();
        logic [ADDR_W-1:0] addr;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0)
                addr = 7'h7F;
            else if (phase == 1)
                addr = 7'h00;
            else
                addr = ADDR_W'($urandom_range(0, 127));
            write_addr(addr);
            set_idling(phase % 4);
            for (int n = 0; n < OPS_PER_PHASE; n++)
                send_op(random_op());
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_idling(0);
        test_after_reset();
        test_init();
        test_commands();
        set_idling(3);
        test_backlight_and_unknown();
        test_random();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_writes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
